FILE: rtl/core/salcp_pkg.sv
`default_nettype none
package salcp_pkg;

    localparam int MaxLen = 4096;
    localparam int AddrW  = $clog2(MaxLen);
    localparam int LenW   = AddrW + 1;
    localparam int LcpW   = 12;
    localparam int SymW   = 8;
    localparam int StatW  = 2;

    localparam logic [1:0] CmdLoad = 2'd0;
    localparam logic [1:0] CmdRun  = 2'd1;
    localparam logic [1:0] CmdRead = 2'd2;
    localparam logic [1:0] CmdNop  = 2'd3;

    localparam logic [StatW-1:0] StatOk      = 2'd0;
    localparam logic [StatW-1:0] StatNotDone = 2'd1;
    localparam logic [StatW-1:0] StatRange   = 2'd2;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_RANK_RD,
        t_ST_RANK_WR,
        t_ST_POS_RD,
        t_ST_POS_CHK,
        t_ST_NB_WAIT,
        t_ST_TXT_RD,
        t_ST_TXT_CMP,
        t_ST_READ_WAIT,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic rank_rd;
        logic rank_wr;
        logic pos_chk;
        logic nb_rd;
        logic txt_rd;
        logic txt_cmp;
        logic read_rd;
        logic read_fin;
    } t_cmd;

    typedef struct packed {
        logic rank_last;
        logic pos_last;
        logic pos_skip;
        logic rank_end;
        logic txt_stop;
    } t_status;

endpackage
`default_nettype wire

FILE: rtl/core/salcp_datapath.sv
`default_nettype none
module salcp_datapath (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire salcp_pkg::t_cmd        i_cmd,
    output salcp_pkg::t_status          o_status,
    input  wire [salcp_pkg::AddrW-1:0]  i_index,
    input  wire [salcp_pkg::SymW-1:0]   i_symbol,
    input  wire [salcp_pkg::AddrW-1:0]  i_suffix_start,
    input  wire [salcp_pkg::LenW-1:0]   i_text_length,
    output logic [salcp_pkg::LcpW-1:0]  o_lcp_value,
    output logic [salcp_pkg::StatW-1:0] o_stat
);
    import salcp_pkg::*;

    logic [SymW-1:0]  text_mem   [MaxLen];
    logic [AddrW-1:0] suffix_mem [MaxLen];
    logic [AddrW-1:0] rank_mem   [MaxLen];
    logic [LcpW-1:0]  prefix_mem [MaxLen];

    logic [LenW-1:0]  r_len, r_cnt, r_h, r_nb, r_rk;
    logic             r_done;
    logic [AddrW-1:0] r_sfx_q, r_rank_q;
    logic [SymW-1:0]  r_ta_q, r_tb_q;
    logic [LcpW-1:0]  r_pre_q;
    logic [AddrW-1:0] r_ridx;
    logic [LenW-1:0]  n_len, pa, pb;

    assign n_len = (i_text_length > LenW'(MaxLen)) ? LenW'(MaxLen) : i_text_length;
    assign pa = r_cnt + r_h;
    assign pb = r_nb + r_h;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            text_mem[i_index]   <= i_symbol;
            suffix_mem[i_index] <= i_suffix_start;
        end
        if (i_cmd.rank_wr && ({1'b0, r_sfx_q} < r_len)) begin
            rank_mem[r_sfx_q] <= r_cnt[AddrW-1:0];
        end
        if (i_cmd.txt_cmp && o_status.txt_stop) begin
            prefix_mem[r_rk[AddrW-1:0]] <= (r_h > LenW'(4095)) ? LcpW'(4095) : r_h[LcpW-1:0];
        end
        if (i_cmd.pos_chk && !o_status.pos_skip && o_status.rank_end) begin
            prefix_mem[r_rank_q] <= '0;
        end
        r_sfx_q  <= suffix_mem[i_cmd.nb_rd ? (r_rank_q + 1'b1) : r_cnt[AddrW-1:0]];
        r_rank_q <= rank_mem[r_cnt[AddrW-1:0]];
        r_ta_q   <= text_mem[pa[AddrW-1:0]];
        r_tb_q   <= text_mem[pb[AddrW-1:0]];
        r_pre_q  <= prefix_mem[i_index];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_h    <= '0;
            r_nb   <= '0;
            r_rk   <= '0;
            r_ridx <= '0;
        end else begin
            if (i_cmd.load) r_done <= 1'b0;
            if (i_cmd.start) begin
                r_len <= n_len;
                r_cnt <= '0;
                r_h   <= '0;
            end
            if (i_cmd.rank_wr) begin
                r_cnt <= o_status.rank_last ? '0 : r_cnt + 1'b1;
                if (o_status.rank_last) r_h <= '0;
            end
            if (i_cmd.pos_chk) begin
                r_rk <= {1'b0, r_rank_q};
                if (o_status.pos_skip || o_status.rank_end) begin
                    r_h   <= '0;
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.txt_rd) r_nb <= {1'b0, r_sfx_q};
            if (i_cmd.txt_cmp) begin
                if (o_status.txt_stop) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_h != '0) r_h <= r_h - 1'b1;
                end else begin
                    r_h <= r_h + 1'b1;
                end
            end
            if (i_cmd.read_rd) r_ridx <= i_index;
            if (i_cmd.read_fin) r_done <= r_done;
            if (i_cmd.start) r_done <= 1'b1;
        end
    end

    // r_nb loaded on the txt_rd command (NB_WAIT state); text read addresses come from r_cnt + r_h and r_nb + r_h
    logic nb_ok, pa_ok;
    assign pa_ok = pa < r_len;
    assign nb_ok = pb < r_len;

    always_comb begin
        o_status.rank_last = (r_cnt + 1'b1 >= r_len);
        o_status.pos_last  = (r_cnt >= r_len);
        o_status.pos_skip  = ({1'b0, r_rank_q} >= r_len);
        o_status.rank_end  = ({1'b0, r_rank_q} == r_len - 1'b1);
        o_status.txt_stop  = !pa_ok || !nb_ok || (r_ta_q != r_tb_q);
    end

    always_comb begin
        if (!r_done) begin
            o_stat = StatNotDone; o_lcp_value = '0;
        end else if ({1'b0, r_ridx} >= r_len) begin
            o_stat = StatRange; o_lcp_value = '0;
        end else begin
            o_stat = StatOk; o_lcp_value = r_pre_q;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/salcp_ctrl.sv
`default_nettype none
module salcp_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire [1:0]           i_in_cmd,
    output logic                o_in_ready,
    output logic                o_res_load,
    output logic                o_res_read,
    input  wire                 i_out_free,
    output salcp_pkg::t_cmd     o_cmd,
    input  wire salcp_pkg::t_status i_status
);
    import salcp_pkg::*;

    t_state r_state, n_state;
    logic   acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_ST_IDLE;
        else          r_state <= n_state;
    end

    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        o_res_load = 1'b0;
        o_res_read = 1'b0;
        case (r_state)
            t_ST_IDLE: begin
                o_in_ready = i_out_free;
                if (acc) begin
                    case (i_in_cmd)
                        CmdLoad: begin o_cmd.load = 1'b1; o_res_load = 1'b1; end
                        CmdRun:  begin o_cmd.start = 1'b1; n_state = t_ST_RANK_RD; end
                        CmdRead: begin o_cmd.read_rd = 1'b1; n_state = t_ST_READ_WAIT; end
                        default: o_res_load = 1'b1;
                    endcase
                end
            end
            t_ST_RANK_RD: begin
                if (i_status.pos_last) n_state = t_ST_POS_RD;
                else n_state = t_ST_RANK_WR;
            end
            t_ST_RANK_WR: begin
                o_cmd.rank_wr = 1'b1;
                n_state = i_status.rank_last ? t_ST_POS_RD : t_ST_RANK_RD;
            end
            t_ST_POS_RD: begin
                if (i_status.pos_last) begin
                    o_res_load = 1'b1;
                    n_state = t_ST_OUT;
                end else begin
                    n_state = t_ST_POS_CHK;
                end
            end
            t_ST_POS_CHK: begin
                o_cmd.pos_chk = 1'b1;
                o_cmd.nb_rd   = 1'b1;
                n_state = t_ST_NB_WAIT;
            end
            t_ST_NB_WAIT: begin
                if (i_status.pos_skip || i_status.rank_end) n_state = t_ST_POS_RD;
                else begin
                    o_cmd.txt_rd = 1'b1;
                    n_state = t_ST_TXT_RD;
                end
            end
            t_ST_TXT_RD: n_state = t_ST_TXT_CMP;
            t_ST_TXT_CMP: begin
                o_cmd.txt_cmp = 1'b1;
                n_state = i_status.txt_stop ? t_ST_POS_RD : t_ST_TXT_RD;
            end
            t_ST_READ_WAIT: begin
                o_cmd.read_fin = 1'b1;
                o_res_read = 1'b1;
                n_state = t_ST_OUT;
            end
            t_ST_OUT: n_state = t_ST_IDLE;
            default: n_state = t_ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/core/suffix_array_lcp_builder_core.sv
`default_nettype none
// Kasai LCP builder. Load (cmd 0) and no-op items each return a result from the
// idle state and can follow back to back; read items pass through the read-wait
// and output states, through registered reads of the 4096-entry stores. A run
// item of length n takes a rank pass (rank read and rank write per entry),
// position visits (position read, check and neighbour wait), compare steps
// (text read and compare; one per matched symbol, under 2n over the run, plus
// one closing compare per position not skipped and not at the last rank) and
// returns through the output state. One result transaction is returned per
// item; a result waiting in the output register holds off the next item.
module suffix_array_lcp_builder_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: cmd[1:0], index[13:2], symbol[21:14], suffix_start[33:22],
    //        text_length[46:34], zero fill [47]
    input  wire  [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: lcp_value[11:0], status[13:12], zero fill [15:14]
    output logic [15:0] m_axis_tdata
);
    import salcp_pkg::*;

    t_cmd             cmd;
    t_status          st;
    logic             res_load, res_read, out_free;
    logic [LcpW-1:0]  lcp;
    logic [StatW-1:0] stat;
    logic             r_ovalid;
    logic [15:0]      r_odata;

    assign out_free = !r_ovalid || m_axis_tready;

    salcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_cmd   (s_axis_tdata[1:0]),
        .o_in_ready (s_axis_tready),
        .o_res_load (res_load),
        .o_res_read (res_read),
        .i_out_free (out_free),
        .o_cmd      (cmd),
        .i_status   (st)
    );

    salcp_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (st),
        .i_index        (s_axis_tdata[13:2]),
        .i_symbol       (s_axis_tdata[21:14]),
        .i_suffix_start (s_axis_tdata[33:22]),
        .i_text_length  (s_axis_tdata[46:34]),
        .o_lcp_value    (lcp),
        .o_stat         (stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (res_load || res_read) r_ovalid <= 1'b1;
            else if (m_axis_tready)   r_ovalid <= 1'b0;
        end
        if (res_read)      r_odata <= {2'b00, stat, lcp};
        else if (res_load) r_odata <= '0;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule
`default_nettype wire

FILE: rtl/core/salcp_checker.sv
`default_nettype none
module salcp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[13:12] != 2'd3))
        else $error("bad status");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[13:12] != 2'd0) |-> (m_axis_tdata[11:0] == 12'd0))
        else $error("lcp nonzero with error status");
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result waits");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped");
endmodule

bind suffix_array_lcp_builder_core salcp_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

FILE: sim/salcp_lcp_checker.sv
module salcp_lcp_checker
    import salcp_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_tvalid,
    input  wire        i_in_tready,
    // cmd[1:0], index[13:2], symbol[21:14], suffix_start[33:22], text_length[46:34]
    input  wire [47:0] i_in_tdata,
    input  wire        i_out_tvalid,
    input  wire        i_out_tready,
    // lcp_value[11:0], status[13:12]
    input  wire [15:0] i_out_tdata,
    output int         o_errors,
    output int         o_pending,
    output int         o_checked
);

    typedef struct packed {
        logic [StatW-1:0] status;
        logic [LcpW-1:0]  lcp;
    } lcp_result_t;

    logic [SymW-1:0]  text_mem   [MaxLen];
    logic [AddrW-1:0] sa_mem     [MaxLen];
    logic [AddrW-1:0] rank_mem   [MaxLen];
    logic [LcpW-1:0]  lcp_mem    [MaxLen];
    logic [LenW-1:0]  text_len;
    bit               lcp_valid;

    lcp_result_t lcp_expected_q[$];

    assign o_pending = lcp_expected_q.size();

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        o_errors++;
    endtask

    // Kasai pass over the first n symbols
    task automatic kasai_build(input int n);
        int h;
        int rk;
        int nb;
        h = 0;
        for (int r = 0; r < n; r++) begin
            if (int'(sa_mem[r]) < n)
                rank_mem[sa_mem[r]] = AddrW'(r);
        end
        for (int p = 0; p < n; p++) begin
            rk = int'(rank_mem[p]);
            if (rk >= n) begin
                h = 0;
            end else if (rk == n - 1) begin
                lcp_mem[rk] = '0;
                h = 0;
            end else begin
                nb = int'(sa_mem[rk + 1]);
                while (p + h < n && nb + h < n && text_mem[p + h] == text_mem[nb + h])
                    h++;
                lcp_mem[rk] = (h > 4095) ? LcpW'(4095) : LcpW'(h);
                if (h > 0)
                    h--;
            end
        end
    endtask

    task automatic predict(input logic [47:0] d);
        logic [1:0]       cmd;
        logic [AddrW-1:0] idx;
        logic [LenW-1:0]  len;
        lcp_result_t      res;
        cmd = d[1:0];
        idx = d[13:2];
        len = d[46:34];
        res = '{lcp: '0, status: StatOk};
        case (cmd)
            CmdLoad: begin
                text_mem[idx] = d[21:14];
                sa_mem[idx]   = d[33:22];
                lcp_valid     = 1'b0;
            end
            CmdRun: begin
                text_len = (len > LenW'(MaxLen)) ? LenW'(MaxLen) : len;
                kasai_build(int'(text_len));
                lcp_valid = 1'b1;
            end
            CmdRead: begin
                if (!lcp_valid)
                    res.status = StatNotDone;
                else if ({1'b0, idx} >= text_len)
                    res.status = StatRange;
                else
                    res.lcp = lcp_mem[idx];
            end
            default: ;
        endcase
        lcp_expected_q.push_back(res);
    endtask

    always @(posedge i_clk) begin
        lcp_result_t want;
        lcp_result_t got;
        if (!i_rst_n) begin
            text_len  <= '0;
            lcp_valid <= 1'b0;
        end else begin
            if (i_in_tvalid && i_in_tready)
                predict(i_in_tdata);
            if (i_out_tvalid && i_out_tready) begin
                got = i_out_tdata[13:0];
                o_checked++;
                if (lcp_expected_q.size() == 0) begin
                    report($sformatf("unexpected result lcp=%0d status=%0d",
                                     got.lcp, got.status));
                end else begin
                    want = lcp_expected_q.pop_front();
                    if (got.lcp !== want.lcp)
                        report($sformatf("lcp_value %0d, want %0d", got.lcp, want.lcp));
                    if (got.status !== want.status)
                        report($sformatf("status %0d, want %0d", got.status, want.status));
                end
            end
        end
    end

    initial begin
        o_errors  = 0;
        o_checked = 0;
    end

endmodule

FILE: sim/suffix_array_lcp_builder_core_tb.sv
module suffix_array_lcp_builder_core_tb;
    import salcp_pkg::*;

    localparam int CycleLimit = 3000000;
    localparam int FillLen    = 64;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // cmd, index, symbol, suffix_start, text_length
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // lcp_value, status

    int errors;
    int pending;
    int checked;
    int sent;
    int cycles;
    int n_load, n_run, n_read, n_other;
    bit hold_done;

    logic [47:0] item_q[$];

    suffix_array_lcp_builder_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    salcp_lcp_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_in_tready  (s_axis_tready),
        .i_in_tdata   (s_axis_tdata),
        .i_out_tvalid (m_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .i_out_tdata  (m_axis_tdata),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_item(input logic [1:0] cmd, input int idx, input int sym,
                            input int sfx, input int len);
        item_q.push_back({1'b0, LenW'(len), AddrW'(sfx), SymW'(sym), AddrW'(idx), cmd});
        case (cmd)
            CmdLoad: n_load++;
            CmdRun:  n_run++;
            CmdRead: n_read++;
            default: n_other++;
        endcase
    endtask

    function automatic bit suffix_less(ref logic [7:0] t[64], input int a, input int b,
                                       input int n);
        int k;
        k = 0;
        while (a + k < n && b + k < n) begin
            if (t[a + k] != t[b + k])
                return t[a + k] < t[b + k];
            k++;
        end
        return a + k == n;
    endfunction

    // load a text with its suffix array (sometimes with one entry corrupted), run, read back every rank
    task automatic text_sequence(input int n);
        logic [7:0] txt[64];
        int         sa[64];
        int         alpha;
        int         tmp;
        int         j;
        alpha = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
            txt[i] = (alpha == 256) ? $urandom_range(0, 255) : $urandom_range(0, alpha - 1);
            sa[i]  = i;
        end
        for (int i = 1; i < n; i++) begin
            tmp = sa[i];
            j   = i - 1;
            while (j >= 0 && suffix_less(txt, tmp, sa[j], n)) begin
                sa[j + 1] = sa[j];
                j--;
            end
            sa[j + 1] = tmp;
        end
        if ($urandom_range(0, 5) == 0)
            sa[$urandom_range(0, n - 1)] = $urandom_range(0, 4095);
        for (int i = 0; i < n; i++)
            add_item(CmdLoad, i, txt[i], sa[i], 0);
        add_item(CmdRun, 0, 0, 0, n);
        for (int r = 0; r < n; r++)
            add_item(CmdRead, r, 0, 0, 0);
        if ($urandom_range(0, 1))
            add_item(CmdRead, $urandom_range(n, 4095), 0, 0, 0);
    endtask

    task automatic noise_item();
        int len;
        len = $urandom_range(0, FillLen);
        add_item(2'($urandom_range(0, 3)), $urandom_range(0, 4095), $urandom_range(0, 255),
                 $urandom_range(0, 4095), len);
    endtask

    task automatic build_stimulus();
        int perm[FillLen];
        int tmp;
        int j;
        int random_items;
        add_item(CmdRead, 0, 0, 0, 0);
        add_item(CmdNop, 4095, 255, 4095, 8191);
        add_item(CmdRun, 0, 0, 0, 0);
        add_item(CmdRead, 0, 0, 0, 0);
        add_item(CmdRead, 4095, 0, 0, 0);
        // fill the low store entries once so later runs never touch unwritten data
        for (int i = 0; i < FillLen; i++)
            perm[i] = i;
        for (int i = FillLen - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < FillLen; i++)
            add_item(CmdLoad, i, (i < 32) ? $urandom_range(0, 1) : $urandom_range(0, 255),
                     perm[i], 0);
        add_item(CmdRun, 0, 0, 0, FillLen);
        add_item(CmdRead, 0, 0, 0, 0);
        add_item(CmdRead, FillLen - 1, 0, 0, 0);
        add_item(CmdRead, FillLen - 2, 0, 0, 0);
        add_item(CmdRead, $urandom_range(0, 4095), 0, 0, 0);
        add_item(CmdLoad, 4095, 255, 0, 0);
        add_item(CmdRead, 1, 0, 0, 0);
        add_item(CmdRun, 0, 0, 0, 1);
        add_item(CmdRead, 0, 0, 0, 0);
        add_item(CmdRead, 1, 0, 0, 0);
        add_item(CmdRun, 0, 0, 0, FillLen);
        add_item(CmdRead, FillLen / 2, 0, 0, 0);
        random_items = 0;
        while (random_items < 420) begin
            if ($urandom_range(0, 3) != 0) begin
                tmp = item_q.size();
                text_sequence($urandom_range(1, 24));
                random_items += item_q.size() - tmp;
            end else begin
                repeat ($urandom_range(1, 4)) noise_item();
                random_items += 1;
            end
        end
    endtask

    // sender: bursts with random gaps
    initial begin
        int burst_left;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        n_load = 0; n_run = 0; n_read = 0; n_other = 0;
        sent = 0;
        cycles = 0;
        build_stimulus();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = 0;
        while (item_q.size() > 0) begin
            if (burst_left == 0) begin
                if ($urandom_range(0, 2) != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= item_q.pop_front();
            do @(posedge i_clk); while (!s_axis_tready);
            sent++;
            burst_left--;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("sent %0d loads, %0d runs, %0d reads, %0d other items", n_load, n_run,
                 n_read, n_other);
        $display("%0d results compared", checked);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // receiver: changing stall pattern, one long hold-off mid run
    initial begin
        int mode;
        int stretch;
        hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!hold_done && sent >= 150) begin
                hold_done = 1'b1;
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(5, 60);
            repeat (stretch) begin
                @(negedge i_clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

endmodule
